/* src/spq_pkg.sv */
// Shared types and codes for the sorted priority queue.
package spq_pkg;

    typedef enum logic [0:0] {
        S_IDLE,
        S_WORK
    } t_state;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    typedef struct packed {
        logic    load;
        logic    report;
        logic    do_enq;
        logic    do_deq;
        t_status code;
    } t_cmd;

    typedef struct packed {
        logic req_deq;
        logic full;
        logic empty;
    } t_dp_status;

endpackage

/* src/spq_ctrl.sv */
// Controller state machine that sequences each request through the datapath.
module spq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  spq_pkg::t_dp_status i_dp_status,
    output spq_pkg::t_cmd      o_cmd
);
    import spq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_WORK;
                end
            end
            S_WORK: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        busy         = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.report = 1'b0;
        o_cmd.do_enq = 1'b0;
        o_cmd.do_deq = 1'b0;
        o_cmd.code   = ST_DONE;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = start;
            end
            S_WORK: begin
                busy         = 1'b1;
                o_cmd.report = 1'b1;
                if (i_dp_status.req_deq) begin
                    o_cmd.do_deq = !i_dp_status.empty;
                    o_cmd.code   = i_dp_status.empty ? ST_EMPTY : ST_DONE;
                end else begin
                    o_cmd.do_enq = !i_dp_status.full;
                    o_cmd.code   = i_dp_status.full ? ST_FULL : ST_DONE;
                end
            end
            default: begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

/* src/spq_datapath.sv */
// Datapath with the sorted row of entry cells, the fill count and the result registers.
module spq_datapath #(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 32,
    parameter int PRIO_BITS  = 8,
    parameter int CNT_W      = $clog2(CAPACITY + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  spq_pkg::t_cmd          i_cmd,
    output spq_pkg::t_dp_status    o_dp_status,
    input  logic                   i_req_type,
    input  logic [VALUE_BITS-1:0]  i_item_value,
    input  logic [PRIO_BITS-1:0]   i_item_priority,
    output logic                   o_strobe,
    output logic [VALUE_BITS-1:0]  o_out_value,
    output logic [PRIO_BITS-1:0]   o_out_priority,
    output logic [1:0]             o_status,
    output logic [CNT_W-1:0]       o_fill_count
);
    import spq_pkg::*;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic                  r_req_type;
    logic [VALUE_BITS-1:0] r_req_value;
    logic [PRIO_BITS-1:0]  r_req_prio;

    logic [VALUE_BITS-1:0] r_val [CAPACITY];
    logic [PRIO_BITS-1:0]  r_pri [CAPACITY];
    logic [CAPACITY-1:0]   ge;

    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;

    logic                  r_strobe;
    logic [VALUE_BITS-1:0] r_out_value;
    logic [PRIO_BITS-1:0]  r_out_priority;
    logic [1:0]            r_status;
    logic [CNT_W-1:0]      r_fill_count;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req_type  <= i_req_type;
            r_req_value <= i_item_value;
            r_req_prio  <= i_item_priority;
        end
    end

    assign o_dp_status.req_deq = (r_req_type == REQ_DEQ);
    assign o_dp_status.full    = (r_count >= CAP_CNT);
    assign o_dp_status.empty   = (r_count == '0);

    // A cell at or past the insertion point takes the new entry or its left neighbor.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        assign ge[i] = (CNT_W'(i) >= r_count) || (r_pri[i] > r_req_prio);

        always_ff @(posedge i_clk) begin
            if (i_cmd.do_enq && ge[i]) begin
                if (i == 0) begin
                    r_val[i] <= r_req_value;
                    r_pri[i] <= r_req_prio;
                end else if (!ge[(i == 0) ? 0 : i - 1]) begin
                    r_val[i] <= r_req_value;
                    r_pri[i] <= r_req_prio;
                end else begin
                    r_val[i] <= r_val[(i == 0) ? 0 : i - 1];
                    r_pri[i] <= r_pri[(i == 0) ? 0 : i - 1];
                end
            end else if (i_cmd.do_deq && (i < CAPACITY - 1)) begin
                r_val[i] <= r_val[(i < CAPACITY - 1) ? i + 1 : i];
                r_pri[i] <= r_pri[(i < CAPACITY - 1) ? i + 1 : i];
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.do_enq) begin
            n_count = r_count + 1'b1;
        end else if (i_cmd.do_deq) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_strobe <= i_cmd.report;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.report) begin
            r_out_value    <= i_cmd.do_deq ? r_val[0] : '0;
            r_out_priority <= i_cmd.do_deq ? r_pri[0] : '0;
            r_status       <= i_cmd.code;
            r_fill_count   <= n_count;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_out_value    = r_out_value;
    assign o_out_priority = r_out_priority;
    assign o_status       = r_status;
    assign o_fill_count   = r_fill_count;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_CNT)
        else $error("fill count exceeds capacity");

    a_enq_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.do_enq |=> r_count == $past(r_count) + 1'b1)
        else $error("enqueue did not add one entry");

    a_empty_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status == ST_EMPTY)) |-> (o_fill_count == '0))
        else $error("empty dequeue reported with entries held");

    a_sorted_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.do_enq && (r_count == '0)) |=> (r_pri[0] == $past(r_req_prio)))
        else $error("enqueue into empty queue missed the head cell");
`endif

endmodule

/* src/sorted_priority_queue.sv */
// Top level of the sorted priority queue: controller and datapath.
// Each request is handled in two states: the cycle start is accepted captures it, and the
// next cycle compares its priority against every held entry in parallel and shifts the
// row of entry cells in one step. The result appears on the cycle after that with
// o_strobe high for one cycle and must be taken then; busy is already low in that cycle,
// so a new request may start alongside it; none is accepted while busy is high.
// Equal priorities leave in arrival order; an enqueue to a full queue reports status 1
// and a dequeue from an empty queue reports status 2, neither changing the contents.
module sorted_priority_queue #(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 32,
    parameter int PRIO_BITS  = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_req_type,
    input  logic [VALUE_BITS-1:0]             i_item_value,
    input  logic [PRIO_BITS-1:0]              i_item_priority,
    output logic                              o_strobe,
    output logic [VALUE_BITS-1:0]             o_out_value,
    output logic [PRIO_BITS-1:0]              o_out_priority,
    output logic [1:0]                        o_status,
    output logic [$clog2(CAPACITY + 1)-1:0]   o_fill_count
);
    import spq_pkg::*;

    t_cmd       cmd;
    t_dp_status dp_status;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_dp_status (dp_status),
        .o_cmd       (cmd)
    );

    spq_datapath #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS),
        .PRIO_BITS  (PRIO_BITS),
        .CNT_W      ($clog2(CAPACITY + 1))
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_dp_status     (dp_status),
        .i_req_type      (i_req_type),
        .i_item_value    (i_item_value),
        .i_item_priority (i_item_priority),
        .o_strobe        (o_strobe),
        .o_out_value     (o_out_value),
        .o_out_priority  (o_out_priority),
        .o_status        (o_status),
        .o_fill_count    (o_fill_count)
    );

endmodule

/* dv/spq_checker.sv */
// Watches the request and result channels of the sorted priority queue, predicts and compares.
module spq_checker #(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 32,
    parameter int PRIO_BITS  = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic                                i_busy,
    input  logic                                i_req_type,
    input  logic [VALUE_BITS-1:0]               i_item_value,
    input  logic [PRIO_BITS-1:0]                i_item_priority,
    input  logic                                i_strobe,
    input  logic [VALUE_BITS-1:0]               i_out_value,
    input  logic [PRIO_BITS-1:0]                i_out_priority,
    input  logic [1:0]                          i_status,
    input  logic [$clog2(CAPACITY + 1)-1:0]     i_fill_count,
    output int                                  o_mismatches,
    output int                                  o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int FILL_BITS = $clog2(CAPACITY + 1);

    typedef struct {
        logic [VALUE_BITS-1:0] value;
        logic [PRIO_BITS-1:0]  prio;
        t_status               status;
        logic [FILL_BITS-1:0]  fill;
    } t_queue_result;

    logic [VALUE_BITS-1:0] held_values [CAPACITY];
    logic [PRIO_BITS-1:0]  held_prios [CAPACITY];
    int                    held_count;
    t_queue_result         awaited_results [$];
    int                    mismatch_total;

    // Applies one request to the held entries and returns the result it must produce.
    task automatic serve_request(
        input  logic                  req,
        input  logic [VALUE_BITS-1:0] value,
        input  logic [PRIO_BITS-1:0]  prio,
        output t_queue_result         res
    );
        int slot;
        int k;
        res.value  = '0;
        res.prio   = '0;
        res.status = ST_DONE;
        if (req == REQ_ENQ) begin
            if (held_count >= CAPACITY) begin
                res.status = ST_FULL;
            end else begin
                slot = 0;
                while (slot < held_count && held_prios[slot] <= prio) slot++;
                for (k = held_count; k > slot; k--) begin
                    held_values[k] = held_values[k-1];
                    held_prios[k]  = held_prios[k-1];
                end
                held_values[slot] = value;
                held_prios[slot]  = prio;
                held_count++;
            end
        end else if (held_count == 0) begin
            res.status = ST_EMPTY;
        end else begin
            res.value = held_values[0];
            res.prio  = held_prios[0];
            for (k = 1; k < held_count; k++) begin
                held_values[k-1] = held_values[k];
                held_prios[k-1]  = held_prios[k];
            end
            held_count--;
        end
        res.fill = FILL_BITS'(held_count);
    endtask

    always @(posedge i_clk) begin : watch
        t_queue_result want;
        if (!i_rst_n) begin
            held_count = 0;
            awaited_results.delete();
        end else begin
            // The result leaving now belongs to an earlier request than one accepted now.
            if (i_strobe) begin
                if (awaited_results.size() == 0) begin
                    mismatch_total++;
                    if (mismatch_total <= 10) begin
                        $display("%0t: result with no request waiting:", $realtime,
                                 " value %h prio %h status %0d fill %0d",
                                 i_out_value, i_out_priority, i_status, i_fill_count);
                    end
                end else begin
                    want = awaited_results.pop_front();
                    if (i_out_value !== want.value || i_out_priority !== want.prio ||
                        i_status !== want.status || i_fill_count !== want.fill) begin
                        mismatch_total++;
                        if (mismatch_total <= 10) begin
                            $display("%0t: expected value %h prio %h status %0d fill %0d,",
                                     $realtime, want.value, want.prio, want.status,
                                     want.fill,
                                     " got value %h prio %h status %0d fill %0d",
                                     i_out_value, i_out_priority, i_status, i_fill_count);
                        end
                    end
                end
            end
            if (i_start && !i_busy) begin
                serve_request(i_req_type, i_item_value, i_item_priority, want);
                awaited_results.push_back(want);
            end
        end
        o_outstanding <= awaited_results.size();
        o_mismatches  <= mismatch_total;
    end

endmodule

/* dv/tb.sv */
// Testbench top for the sorted priority queue: clock, reset, request stimulus and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int CAPACITY        = 16;
    localparam int VALUE_BITS      = 32;
    localparam int PRIO_BITS       = 8;
    localparam int FILL_BITS       = $clog2(CAPACITY + 1);
    localparam int RANDOM_REQUESTS = 400;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic                  i_req_type;
    logic [VALUE_BITS-1:0] i_item_value;
    logic [PRIO_BITS-1:0]  i_item_priority;
    logic                  o_strobe;
    logic [VALUE_BITS-1:0] o_out_value;
    logic [PRIO_BITS-1:0]  o_out_priority;
    logic [1:0]            o_status;
    logic [FILL_BITS-1:0]  o_fill_count;
    int                    mismatches;
    int                    outstanding;
    int                    burst_left = 4;

    sorted_priority_queue #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS),
        .PRIO_BITS  (PRIO_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_req_type      (i_req_type),
        .i_item_value    (i_item_value),
        .i_item_priority (i_item_priority),
        .o_strobe        (o_strobe),
        .o_out_value     (o_out_value),
        .o_out_priority  (o_out_priority),
        .o_status        (o_status),
        .o_fill_count    (o_fill_count)
    );

    spq_checker #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS),
        .PRIO_BITS  (PRIO_BITS)
    ) order_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_req_type      (i_req_type),
        .i_item_value    (i_item_value),
        .i_item_priority (i_item_priority),
        .i_strobe        (o_strobe),
        .i_out_value     (o_out_value),
        .i_out_priority  (o_out_priority),
        .i_status        (o_status),
        .i_fill_count    (o_fill_count),
        .o_mismatches    (mismatches),
        .o_outstanding   (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Presents one request, holds it until accepted, then may pause for a gap when a burst ends.
    task automatic issue(
        input logic                  req,
        input logic [VALUE_BITS-1:0] value,
        input logic [PRIO_BITS-1:0]  prio
    );
        int gap;
        start           <= 1'b1;
        i_req_type      <= req;
        i_item_value    <= value;
        i_item_priority <= prio;
        do @(posedge i_clk); while (busy);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        int                    enq_pct;
        int                    pick;
        logic                  req;
        logic [VALUE_BITS-1:0] value;
        logic [PRIO_BITS-1:0]  prio;
        start           <= 1'b0;
        i_req_type      <= REQ_ENQ;
        i_item_value    <= '0;
        i_item_priority <= '0;
        i_rst_n         <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        issue(REQ_DEQ, '1, '1);
        for (int i = 0; i < CAPACITY; i++) begin
            case (i % 4)
                0:       prio = '1;
                1:       prio = '0;
                2:       prio = 8'h7F;
                default: prio = PRIO_BITS'(i);
            endcase
            value = (i == 1) ? '1 : VALUE_BITS'(i) * 32'h1111_1111;
            issue(REQ_ENQ, value, prio);
        end
        issue(REQ_ENQ, 32'h1234_5678, '0);
        repeat (6) issue(REQ_DEQ, 32'hDEAD_BEEF, 8'h5A);

        // Phases favour enqueues, dequeues or neither so the queue swings between full and empty.
        enq_pct = 50;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 40 == 0) begin
                pick    = $urandom_range(0, 2);
                enq_pct = (pick == 0) ? 15 : (pick == 1) ? 50 : 85;
            end
            req  = ($urandom_range(0, 99) < enq_pct) ? REQ_ENQ : REQ_DEQ;
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                prio = PRIO_BITS'($urandom_range(0, 3));
            end else if (pick == 6) begin
                prio = '0;
            end else if (pick == 7) begin
                prio = '1;
            end else begin
                prio = PRIO_BITS'($urandom);
            end
            value = VALUE_BITS'($urandom);
            issue(req, value, prio);
        end
        start <= 1'b0;

        do @(posedge i_clk); while (outstanding != 0);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
